// File: src/eye_center_gradient_vote_defines.svh
// assertion macros for the eye centre gradient vote checker
`ifndef EYE_CENTER_GRADIENT_VOTE_DEFINES_SVH
`define EYE_CENTER_GRADIENT_VOTE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ECGV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ecgv check failed");

// next-cycle implication, disabled during reset
`define ECGV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ecgv check failed");

// state right after a reset cycle
`define ECGV_ASSERT_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("ecgv reset check failed");

`endif

// File: src/ecgv_pkg.sv
// shared types and constants of the eye centre gradient vote block
`timescale 1ns / 1ps
package ecgv_pkg;

   localparam int MAX_SIDE_DEFAULT       = 64;
   localparam int GRAD_FRAC_BITS_DEFAULT = 14;
   localparam int GRAD_W                 = 16;
   localparam int WEIGHT_W               = 8;
   localparam int REG_W                  = 7;
   localparam int POS_W                  = 6;
   localparam int SCORE_W                = 40;
   localparam int CSR_DATA_W             = 32;
   localparam int CSR_ADDR_W             = 3;

   localparam logic [REG_W-1:0]   SIDE_RESET = 7'd64;
   localparam logic [SCORE_W-1:0] SCORE_MAX  = {SCORE_W{1'b1}};

   typedef enum logic [0:0] {
      REG_IMAGE_COLS = 1'b0,
      REG_IMAGE_ROWS = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_VOTE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0]      pixel_weight;
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]   center_x;
      logic [POS_W-1:0]   center_y;
      logic [SCORE_W-1:0] best_score;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic closing;
   } vote_tag_type;

endpackage

// File: src/ecgv_cell.sv
// one restoring-division cell: one quotient bit per cell, registered to the next
`timescale 1ns / 1ps
module ecgv_cell #(
   parameter int NW = 34,
   parameter int DW = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ecgv_pkg::vote_tag_type tag_in,
   input  logic [DW-1:0]        rem_in,
   input  logic [NW-1:0]        num_in,
   input  logic [NW-1:0]        quo_in,
   input  logic [DW-1:0]        div_in,
   output ecgv_pkg::vote_tag_type tag_out,
   output logic [DW-1:0]        rem_out,
   output logic [NW-1:0]        num_out,
   output logic [NW-1:0]        quo_out,
   output logic [DW-1:0]        div_out
);

   ecgv_pkg::vote_tag_type tag_ff;
   logic [DW-1:0] rem_ff, rem_in_next;
   logic [NW-1:0] num_ff, quo_ff;
   logic [DW-1:0] div_ff;
   logic [DW:0]   trial;
   logic          fits;

   assign trial       = {rem_in, num_in[NW-1]};
   assign fits        = trial >= {1'b0, div_in};
   assign rem_in_next = fits ? DW'(trial - {1'b0, div_in}) : DW'(trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in_next;
      num_ff <= {num_in[NW-2:0], 1'b0};
      quo_ff <= {quo_in[NW-2:0], fits};
      div_ff <= div_in;
   end

   assign tag_out = tag_ff;
   assign rem_out = rem_ff;
   assign num_out = num_ff;
   assign quo_out = quo_ff;
   assign div_out = div_ff;

endmodule

// File: src/ecgv_score.sv
// per-centre saturating accumulation and first-maximum tracking
`timescale 1ns / 1ps
module ecgv_score #(
   parameter int CW = 6,
   parameter int NW = 34
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic [CW-1:0]          cols_m1,
   input  ecgv_pkg::vote_tag_type vote_tag,
   input  logic [NW-1:0]          vote_q,
   output logic                   rsp_valid,
   output ecgv_pkg::rsp_type      rsp_data
);

   localparam int SUMW = ((NW > ecgv_pkg::SCORE_W) ? NW : ecgv_pkg::SCORE_W) + 1;

   logic [ecgv_pkg::SCORE_W-1:0] acc_ff, acc_in, best_ff, best_in, sum_sat;
   logic [CW-1:0] cx_ff, cx_in, cy_ff, cy_in, bx_ff, bx_in, by_ff, by_in;
   logic [SUMW-1:0] sum;
   logic valid_ff, valid_in;
   ecgv_pkg::rsp_type data_ff, data_in;

   assign sum     = SUMW'(acc_ff) + SUMW'(vote_q);
   assign sum_sat = (sum > SUMW'(ecgv_pkg::SCORE_MAX)) ? ecgv_pkg::SCORE_MAX
                                                        : sum[ecgv_pkg::SCORE_W-1:0];

   always_comb begin
      acc_in   = acc_ff;
      best_in  = best_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      valid_in = 1'b0;
      if (clear) begin
         acc_in  = '0;
         best_in = '0;
         cx_in   = '0;
         cy_in   = '0;
         bx_in   = '0;
         by_in   = '0;
      end else if (vote_tag.valid) begin
         acc_in = sum_sat;
         if (vote_tag.last) begin
            acc_in = '0;
            if (sum_sat > best_ff) begin
               best_in = sum_sat;
               bx_in   = cx_ff;
               by_in   = cy_ff;
            end
            if (cx_ff == cols_m1) begin
               cx_in = '0;
               cy_in = cy_ff + 1'b1;
            end else begin
               cx_in = cx_ff + 1'b1;
            end
            valid_in = vote_tag.closing;
         end
      end
      data_in.center_x   = ecgv_pkg::POS_W'(bx_in);
      data_in.center_y   = ecgv_pkg::POS_W'(by_in);
      data_in.best_score = best_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
         best_ff  <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         bx_ff    <= '0;
         by_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         acc_ff   <= acc_in;
         best_ff  <= best_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         bx_ff    <= bx_in;
         by_ff    <= by_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: src/eye_center_gradient_vote.sv
// top level: pixel stores, vote sequencer, vote datapath, divider cell row, scoring
//
// Pixels are written one per cycle while busy is low. The request that carries the
// last pixel of an image starts voting: every (centre, pixel) pair passes through a
// single vote datapath, one pair per clock, and each vote is divided in a row of
// one-bit division cells. An image of N = image_cols * image_rows pixels therefore
// gives N * N pairs to vote on. Once the last vote has been scored, the result is
// shown for one cycle on rsp_valid; the receiver cannot stall it. busy stays high
// from the last pixel until the result cycle. Writing image_cols or image_rows
// discards a partial image.
`timescale 1ns / 1ps
module eye_center_gradient_vote #(
   parameter int MAX_SIDE       = ecgv_pkg::MAX_SIDE_DEFAULT,
   parameter int GRAD_FRAC_BITS = ecgv_pkg::GRAD_FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ecgv_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output ecgv_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ecgv_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ecgv_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ecgv_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int CW    = $clog2(MAX_SIDE);
   localparam int SW    = CW + 1;
   localparam int AW    = 2 * CW;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int GW    = ecgv_pkg::GRAD_W;
   localparam int DXW   = CW + 1;
   localparam int DOTW  = DXW + GW + 1;
   localparam int SQW   = 2 * (DOTW - 1);
   localparam int PW    = SQW + ecgv_pkg::WEIGHT_W;
   localparam int VS    = 2 * GRAD_FRAC_BITS - 8;
   localparam int NW    = PW - VS;
   localparam int DDW   = 2 * CW + 1;

   // configuration
   logic [ecgv_pkg::REG_W-1:0] cols_ff, rows_ff;
   logic csr_write;
   logic [SW-1:0] side_cols, side_rows;
   logic [CW-1:0] cols_m1, rows_m1;
   logic [2*SW-1:0] total;
   logic [AW-1:0] total_m1;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= ecgv_pkg::SIDE_RESET;
         rows_ff <= ecgv_pkg::SIDE_RESET;
      end else if (csr_write) begin
         case (ecgv_pkg::reg_index_type'(paddr[2]))
            ecgv_pkg::REG_IMAGE_COLS: cols_ff <= pwdata[ecgv_pkg::REG_W-1:0];
            ecgv_pkg::REG_IMAGE_ROWS: rows_ff <= pwdata[ecgv_pkg::REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ecgv_pkg::reg_index_type'(paddr[2]))
         ecgv_pkg::REG_IMAGE_COLS: prdata = ecgv_pkg::CSR_DATA_W'(cols_ff);
         ecgv_pkg::REG_IMAGE_ROWS: prdata = ecgv_pkg::CSR_DATA_W'(rows_ff);
         default:                  prdata = '0;
      endcase
   end

   always_comb begin
      if (32'(cols_ff) > 32'(MAX_SIDE)) begin
         side_cols = SW'(MAX_SIDE);
      end else if (cols_ff < 7'd2) begin
         side_cols = SW'(2);
      end else begin
         side_cols = SW'(cols_ff);
      end
      if (32'(rows_ff) > 32'(MAX_SIDE)) begin
         side_rows = SW'(MAX_SIDE);
      end else if (rows_ff < 7'd2) begin
         side_rows = SW'(2);
      end else begin
         side_rows = SW'(rows_ff);
      end
   end

   assign cols_m1  = CW'(side_cols - 1'b1);
   assign rows_m1  = CW'(side_rows - 1'b1);
   assign total    = (2*SW)'(side_cols) * (2*SW)'(side_rows);
   assign total_m1 = AW'(total - 1'b1);

   // sequencer
   ecgv_pkg::state_type state_ff, state_in;
   logic accept, load_done, issue, pix_last, cen_last;
   logic score_valid;
   logic [AW-1:0] count_ff, count_in;
   logic [CW-1:0] px_ff, px_in, py_ff, py_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [AW-1:0] paddr_ff, paddr_in, caddr_ff, caddr_in;

   assign accept    = start & ~busy;
   assign load_done = accept & (count_ff == total_m1);
   assign pix_last  = (px_ff == cols_m1) & (py_ff == rows_m1);
   assign cen_last  = (cx_ff == cols_m1) & (cy_ff == rows_m1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ecgv_pkg::ST_LOAD:  if (load_done) state_in = ecgv_pkg::ST_VOTE;
         ecgv_pkg::ST_VOTE:  if (pix_last & cen_last) state_in = ecgv_pkg::ST_DRAIN;
         ecgv_pkg::ST_DRAIN: if (score_valid) state_in = ecgv_pkg::ST_LOAD;
         default:            state_in = ecgv_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      busy  = 1'b1;
      issue = 1'b0;
      case (state_ff)
         ecgv_pkg::ST_LOAD:  busy = 1'b0;
         ecgv_pkg::ST_VOTE:  issue = 1'b1;
         ecgv_pkg::ST_DRAIN: busy = 1'b1;
         default:            busy = 1'b1;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (csr_write | load_done) begin
         count_in = '0;
      end else if (accept) begin
         count_in = count_ff + 1'b1;
      end
      px_in    = px_ff;
      py_in    = py_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      paddr_in = paddr_ff;
      caddr_in = caddr_ff;
      if (load_done) begin
         px_in    = '0;
         py_in    = '0;
         cx_in    = '0;
         cy_in    = '0;
         paddr_in = '0;
         caddr_in = '0;
      end else if (issue) begin
         if (pix_last) begin
            px_in    = '0;
            py_in    = '0;
            paddr_in = '0;
            caddr_in = caddr_ff + 1'b1;
            if (cx_ff == cols_m1) begin
               cx_in = '0;
               cy_in = cy_ff + 1'b1;
            end else begin
               cx_in = cx_ff + 1'b1;
            end
         end else begin
            paddr_in = paddr_ff + 1'b1;
            if (px_ff == cols_m1) begin
               px_in = '0;
               py_in = py_ff + 1'b1;
            end else begin
               px_in = px_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecgv_pkg::ST_LOAD;
         count_ff <= '0;
         px_ff    <= '0;
         py_ff    <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         paddr_ff <= '0;
         caddr_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         paddr_ff <= paddr_in;
         caddr_ff <= caddr_in;
      end
   end

   // pixel stores
   logic [ecgv_pkg::WEIGHT_W-1:0] weight_mem [DEPTH];
   logic signed [GW-1:0] gx_mem [DEPTH];
   logic signed [GW-1:0] gy_mem [DEPTH];

   logic [ecgv_pkg::WEIGHT_W-1:0] s1_w_ff;
   logic signed [GW-1:0] s1_gx_ff, s1_gy_ff;
   logic [CW-1:0] s1_px_ff, s1_py_ff, s1_cx_ff, s1_cy_ff;
   ecgv_pkg::vote_tag_type issue_tag, s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff;

   assign issue_tag.valid   = issue;
   assign issue_tag.last    = issue & pix_last;
   assign issue_tag.closing = issue & pix_last & cen_last;

   always_ff @(posedge clock) begin
      if (accept) begin
         weight_mem[count_ff] <= req_data.pixel_weight;
         gx_mem[count_ff]     <= req_data.grad_x;
         gy_mem[count_ff]     <= req_data.grad_y;
      end
      s1_w_ff  <= weight_mem[caddr_ff];
      s1_gx_ff <= gx_mem[paddr_ff];
      s1_gy_ff <= gy_mem[paddr_ff];
      s1_px_ff <= px_ff;
      s1_py_ff <= py_ff;
      s1_cx_ff <= cx_ff;
      s1_cy_ff <= cy_ff;
   end

   // dot product and squared distance
   logic signed [DXW-1:0] dx, dy;
   logic signed [DOTW-1:0] dot;
   logic signed [2*DXW-1:0] dx_sq, dy_sq;
   logic signed [DOTW-1:0] s2_dot_ff;
   logic [DDW-1:0] s2_dd_ff, s3_dd_ff, s4_div_ff;
   logic [ecgv_pkg::WEIGHT_W-1:0] s2_w_ff, s3_w_ff;
   logic [DOTW-2:0] mag;
   logic [SQW-1:0] s3_sq_ff;
   logic [PW-1:0] prod;
   logic [NW-1:0] s4_num_ff;

   assign dx    = $signed({1'b0, s1_px_ff}) - $signed({1'b0, s1_cx_ff});
   assign dy    = $signed({1'b0, s1_py_ff}) - $signed({1'b0, s1_cy_ff});
   assign dot   = DOTW'(dx) * DOTW'(s1_gx_ff) + DOTW'(dy) * DOTW'(s1_gy_ff);
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;
   assign mag   = (s2_dot_ff > 0) ? s2_dot_ff[DOTW-2:0] : '0;
   assign prod  = PW'(s3_sq_ff) * PW'(s3_w_ff);

   always_ff @(posedge clock) begin
      s2_dot_ff <= dot;
      s2_dd_ff  <= DDW'(dx_sq) + DDW'(dy_sq);
      s2_w_ff   <= s1_w_ff;
      s3_sq_ff  <= SQW'(mag) * SQW'(mag);
      s3_dd_ff  <= s2_dd_ff;
      s3_w_ff   <= s2_w_ff;
      s4_num_ff <= prod[PW-1:VS];
      s4_div_ff <= (s3_dd_ff == '0) ? DDW'(1) : s3_dd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         s4_tag_ff <= '0;
      end else begin
         s1_tag_ff <= issue_tag;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s3_tag_ff;
      end
   end

   // division cell row
   ecgv_pkg::vote_tag_type tag_c [NW+1];
   logic [DDW-1:0] rem_c [NW+1];
   logic [NW-1:0]  num_c [NW+1];
   logic [NW-1:0]  quo_c [NW+1];
   logic [DDW-1:0] div_c [NW+1];

   assign tag_c[0] = s4_tag_ff;
   assign rem_c[0] = '0;
   assign num_c[0] = s4_num_ff;
   assign quo_c[0] = '0;
   assign div_c[0] = s4_div_ff;

   for (genvar k = 0; k < NW; k++) begin : g_cell
      ecgv_cell #(
         .NW(NW),
         .DW(DDW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tag_in  (tag_c[k]),
         .rem_in  (rem_c[k]),
         .num_in  (num_c[k]),
         .quo_in  (quo_c[k]),
         .div_in  (div_c[k]),
         .tag_out (tag_c[k+1]),
         .rem_out (rem_c[k+1]),
         .num_out (num_c[k+1]),
         .quo_out (quo_c[k+1]),
         .div_out (div_c[k+1])
      );
   end

   ecgv_score #(
      .CW(CW),
      .NW(NW)
   ) u_score (
      .clock     (clock),
      .reset     (reset),
      .clear     (load_done),
      .cols_m1   (cols_m1),
      .vote_tag  (tag_c[NW]),
      .vote_q    (quo_c[NW]),
      .rsp_valid (score_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_valid = score_valid;

endmodule

// File: src/ecgv_checker.sv
// port-level checks of the eye centre gradient vote block
`timescale 1ns / 1ps
`include "eye_center_gradient_vote_defines.svh"
module ecgv_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid
);

   `ECGV_ASSERT_NOW(result_while_busy, rsp_valid, busy)
   `ECGV_ASSERT_NEXT(single_result, rsp_valid, !rsp_valid)
   `ECGV_ASSERT_NEXT(free_after_result, rsp_valid, !busy)
   `ECGV_ASSERT_RESET(idle_after_reset, !busy && !rsp_valid)

endmodule

bind eye_center_gradient_vote ecgv_checker u_ecgv_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// File: sim/eye_center_gradient_vote_tb.sv
// testbench for the eye centre gradient vote block: directed and random images, predicted results
`timescale 1ns / 1ps
module eye_center_gradient_vote_tb;

   localparam int CELLS     = 4096;
   localparam int FRAC      = ecgv_pkg::GRAD_FRAC_BITS_DEFAULT;
   localparam int TOTAL_PIX = 1000;

   typedef struct {
      logic [7:0]        weight;
      logic [15:0]       gx;
      logic [15:0]       gy;
      bit                typed;
      ecgv_pkg::rsp_type centre;
   } pixel_row_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   ecgv_pkg::req_type               req_data;
   logic                            rsp_valid;
   ecgv_pkg::rsp_type               rsp_data;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [ecgv_pkg::CSR_ADDR_W-1:0] paddr;
   logic [ecgv_pkg::CSR_DATA_W-1:0] pwdata;
   logic [ecgv_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   logic [ecgv_pkg::REG_W-1:0] cols_reg, rows_reg;
   byte unsigned      weight_mem [CELLS];
   int                gx_mem [CELLS];
   int                gy_mem [CELLS];
   longint unsigned   sums [CELLS];
   int                pixels_held;
   ecgv_pkg::rsp_type centres_due [$];
   int                mismatches, centres_seen, pixels_sent, images_done;

   pixel_row_type     directed [12];

   eye_center_gradient_vote DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   function automatic int side(input logic [ecgv_pkg::REG_W-1:0] r);
      if (r < 2) return 2;
      if (r > ecgv_pkg::MAX_SIDE_DEFAULT) return ecgv_pkg::MAX_SIDE_DEFAULT;
      return int'(r);
   endfunction

   // locate the best centre once the last pixel of an image is in
   function automatic ecgv_pkg::rsp_type locate_centre(input int cols, input int rows);
      ecgv_pkg::rsp_type res;
      int                best_at;
      longint unsigned   best, vote, num, den, s;
      longint            dx, dy, dot;
      int                at;
      best_at = 0;
      best = 0;
      for (int i = 0; i < CELLS; i++) sums[i] = 0;
      for (int py = 0; py < rows; py++) begin
         for (int px = 0; px < cols; px++) begin
            if (gx_mem[py*cols+px] == 0 && gy_mem[py*cols+px] == 0) continue;
            for (int cy = 0; cy < rows; cy++) begin
               for (int cx = 0; cx < cols; cx++) begin
                  if (cx == px && cy == py) continue;
                  dx = px - cx;
                  dy = py - cy;
                  dot = dx * gx_mem[py*cols+px] + dy * gy_mem[py*cols+px];
                  if (dot <= 0) continue;
                  at = cy * cols + cx;
                  num = longint'(dot) * longint'(dot) * weight_mem[at];
                  den = longint'(dx*dx + dy*dy) << (2*FRAC - 8);
                  vote = num / den;
                  s = sums[at] + vote;
                  if (s > ecgv_pkg::SCORE_MAX) s = ecgv_pkg::SCORE_MAX;
                  sums[at] = s;
               end
            end
         end
      end
      for (int i = 0; i < cols*rows; i++) begin
         if (sums[i] > best) begin
            best = sums[i];
            best_at = i;
         end
      end
      res.center_x = ecgv_pkg::POS_W'(best_at % cols);
      res.center_y = ecgv_pkg::POS_W'(best_at / cols);
      res.best_score = best[ecgv_pkg::SCORE_W-1:0];
      return res;
   endfunction

   // store one accepted pixel, returns 1 when it closes an image
   function automatic bit store_pixel(input ecgv_pkg::req_type px,
                                      output ecgv_pkg::rsp_type centre);
      int cols, rows;
      cols = side(cols_reg);
      rows = side(rows_reg);
      if (pixels_held >= cols*rows) pixels_held = 0;
      weight_mem[pixels_held] = px.pixel_weight;
      gx_mem[pixels_held] = int'($signed(px.grad_x));
      gy_mem[pixels_held] = int'($signed(px.grad_y));
      pixels_held++;
      if (pixels_held < cols*rows) return 0;
      pixels_held = 0;
      centre = locate_centre(cols, rows);
      return 1;
   endfunction

   task automatic send_pixel(input ecgv_pkg::req_type px, input bit typed,
                             input ecgv_pkg::rsp_type want);
      ecgv_pkg::rsp_type centre;
      int                gap;
      start <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      pixels_sent++;
      if (store_pixel(px, centre)) begin
         images_done++;
         centres_due = {centres_due, (typed ? want : centre)};
      end
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (centres_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(input ecgv_pkg::reg_index_type idx,
                            input logic [ecgv_pkg::CSR_DATA_W-1:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ecgv_pkg::CSR_ADDR_W'(4 * idx);
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (idx == ecgv_pkg::REG_IMAGE_COLS) cols_reg = val[ecgv_pkg::REG_W-1:0];
      else rows_reg = val[ecgv_pkg::REG_W-1:0];
      pixels_held = 0;
   endtask

   task automatic csr_check(input ecgv_pkg::reg_index_type idx);
      logic [ecgv_pkg::REG_W-1:0] want;
      want = (idx == ecgv_pkg::REG_IMAGE_COLS) ? cols_reg : rows_reg;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ecgv_pkg::CSR_ADDR_W'(4 * idx);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== ecgv_pkg::CSR_DATA_W'(want))
         report("register read", prdata, want);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure(input logic [ecgv_pkg::CSR_DATA_W-1:0] c,
                            input logic [ecgv_pkg::CSR_DATA_W-1:0] r);
      csr_write(ecgv_pkg::REG_IMAGE_COLS, c);
      csr_write(ecgv_pkg::REG_IMAGE_ROWS, r);
      csr_check(ecgv_pkg::REG_IMAGE_COLS);
      csr_check(ecgv_pkg::REG_IMAGE_ROWS);
   endtask

   function automatic ecgv_pkg::req_type random_pixel();
      ecgv_pkg::req_type px;
      px.pixel_weight = 8'($urandom);
      case ($urandom_range(0, 7))
         0, 1: begin
            px.grad_x = '0;
            px.grad_y = '0;
         end
         2: begin
            px.grad_x = 16'($urandom);
            px.grad_y = 16'($urandom);
         end
         3: begin
            px.grad_x = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            px.grad_y = '0;
         end
         default: begin
            px.grad_x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            px.grad_y = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
         end
      endcase
      return px;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (centres_due.size() == 0) begin
            report("unexpected centre", rsp_data.best_score, 0);
         end else begin
            if (rsp_data.center_x !== centres_due[0].center_x)
               report("center_x", rsp_data.center_x, centres_due[0].center_x);
            if (rsp_data.center_y !== centres_due[0].center_y)
               report("center_y", rsp_data.center_y, centres_due[0].center_y);
            if (rsp_data.best_score !== centres_due[0].best_score)
               report("best_score", rsp_data.best_score, centres_due[0].best_score);
            void'(centres_due.pop_front());
            centres_seen++;
         end
      end
   end

   initial begin
      ecgv_pkg::req_type px;
      ecgv_pkg::rsp_type none;
      int                cols, rows, n, k;
      none = '0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      cols_reg = ecgv_pkg::SIDE_RESET;
      rows_reg = ecgv_pkg::SIDE_RESET;
      pixels_held = 0;
      mismatches = 0;
      centres_seen = 0;
      pixels_sent = 0;
      images_done = 0;
      // no gradients anywhere, then one rightward gradient, then extremes
      directed[0] = '{8'd255, 16'd0, 16'd0, 1'b0, none};
      directed[1] = '{8'd0, 16'd0, 16'd0, 1'b0, none};
      directed[2] = '{8'd255, 16'd0, 16'd0, 1'b0, none};
      directed[3] = '{8'd128, 16'd0, 16'd0, 1'b1, none};
      directed[4] = '{8'd255, 16'd0, 16'd0, 1'b0, none};
      directed[5] = '{8'd255, 16'h4000, 16'd0, 1'b0, none};
      directed[6] = '{8'd255, 16'd0, 16'd0, 1'b0, none};
      directed[7] = '{8'd255, 16'd0, 16'd0, 1'b1, '{6'd0, 6'd0, 40'd65280}};
      directed[8] = '{8'd255, 16'h4000, 16'hC000, 1'b0, none};
      directed[9] = '{8'd0, 16'h8000, 16'h7FFF, 1'b0, none};
      directed[10] = '{8'd1, 16'hFFFF, 16'h8000, 1'b0, none};
      directed[11] = '{8'd255, 16'h7FFF, 16'h7FFF, 1'b0, none};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(ecgv_pkg::REG_IMAGE_COLS);
      csr_check(ecgv_pkg::REG_IMAGE_ROWS);
      // partial image at reset size, dropped by the register writes
      for (int i = 0; i < 3; i++) send_pixel(random_pixel(), 1'b0, none);
      start <= 1'b0;
      configure(2, 2);
      foreach (directed[i]) begin
         px.pixel_weight = directed[i].weight;
         px.grad_x = directed[i].gx;
         px.grad_y = directed[i].gy;
         send_pixel(px, directed[i].typed, directed[i].centre);
      end
      settle();
      // out of range sizes clamp to the limits
      configure(127, 1);
      for (int i = 0; i < 128; i++) send_pixel(random_pixel(), 1'b0, none);
      settle();
      configure(0, 127);
      for (int i = 0; i < 128; i++) send_pixel(random_pixel(), 1'b0, none);
      settle();
      while (pixels_sent < TOTAL_PIX) begin
         cols = $urandom_range(2, 6);
         rows = $urandom_range(2, 6);
         if ($urandom_range(0, 9) == 0) cols = $urandom_range(7, 12);
         configure(cols, rows);
         n = $urandom_range(1, 4);
         for (int j = 0; j < n; j++) begin
            k = cols * rows;
            if ($urandom_range(0, 7) == 0) k = $urandom_range(1, k - 1);
            for (int i = 0; i < k; i++) send_pixel(random_pixel(), 1'b0, none);
         end
         settle();
      end
      settle();
      $display("sent %0d pixels over %0d images, %0d centres checked",
               pixels_sent, images_done, centres_seen);
      $display("sizes from 2 by 2 to the clamped limits, mid-image register writes included");
      if (mismatches == 0 && centres_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
